FILE: rtl/vadpcm_pkg.sv
package vadpcm_pkg;

   localparam int NUM_BOOKS = 16;
   localparam int BOOK_W = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;
   localparam int LANES = 8;
   localparam int SHIFT_FRAC = 11;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_DECODE  = 2'd1,
      REQ_HISTORY = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LANE,
      ST_MERGE,
      ST_EMIT
   } state_type;

   // control from sequencer to lanes
   typedef struct packed {
      logic       mul_en;
      logic       sum_en;
   } lane_ctrl_type;

   function automatic logic signed [31:0] residual_of(input logic [3:0] nib,
                                                      input logic [3:0] scale);
      logic signed [31:0] s4;
      begin
         s4 = 32'(signed'(nib));
         if (scale >= 4'd12) begin
            residual_of = s4 <<< 12;
         end else begin
            residual_of = s4 <<< scale;
         end
      end
   endfunction

   function automatic logic signed [15:0] shift_sat(input logic [31:0] sum);
      logic signed [20:0] s;
      begin
         s = 21'(signed'(sum) >>> SHIFT_FRAC);
         if (s > 21'sd32767) begin
            shift_sat = 16'sh7fff;
         end else if (s < -21'sd32768) begin
            shift_sat = 16'sh8000;
         end else begin
            shift_sat = s[15:0];
         end
      end
   endfunction

endpackage

FILE: rtl/vadpcm_lane.sv
module vadpcm_lane
   import vadpcm_pkg::*;
(
   input  logic                clock,
   input  lane_ctrl_type       ctrl,
   input  logic                clear,
   input  logic signed [15:0]  coef,
   input  logic signed [31:0]  operand,
   output logic [31:0]         acc
);

   logic signed [31:0] prod_ff, prod_in;
   logic [31:0]        acc_ff, acc_in;

   assign prod_in = 32'(coef * operand);

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (ctrl.sum_en) begin
         acc_in = acc_ff + 32'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/order2_adpcm_frame_decoder.sv
// order-2 vadpcm frame decoder. req_type 0 writes one codebook coefficient,
// 2 loads the two history samples and 1 decodes a frame of sixteen residual
// nibbles into sixteen saturated samples, sent one per cycle on rsp_ while
// rsp_stall is low, with rsp_last on the sixteenth. non-decode transactions
// give no result. a frame is handled one half (eight samples) at a time by
// eight parallel multiply-accumulate lanes, one per sample; each lane steps
// through ten product terms. per frame: 16 coefficient reads from the
// codebook memory, then a further fetch step to drain the registered read;
// per half: the lane steps (the last product accumulated in the next cycle),
// a merge (shift, saturate), then eight output samples. a new transaction
// is accepted only in idle, after the last sample of a frame is taken; only
// one transaction is worked on at a time.
module order2_adpcm_frame_decoder
   import vadpcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [3:0]         req_book_select,
   input  logic [3:0]         req_coef_index,
   input  logic signed [15:0] req_coef_value,
   input  logic [3:0]         req_scale,
   input  logic [63:0]        req_residual_nibbles,
   input  logic               req_restart,
   input  logic signed [15:0] req_older_sample,
   input  logic signed [15:0] req_newer_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last
);

   // codebook memory, written on load transactions, read during fetch
   logic signed [15:0] book_mem [NUM_BOOKS*16];
   logic signed [15:0] rd_data_ff;
   logic [BOOK_W+3:0]  rd_addr;
   logic [BOOK_W-1:0]  book_ff, book_in;
   logic [BOOK_W-1:0]  sel_book;

   state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;       // fetch count, lane step, output index
   logic        half_ff, half_in;
   logic signed [15:0] coef_ff [16];
   logic [3:0]  scale_ff;
   logic [63:0] nib_ff;
   logic signed [15:0] hist_old_ff, hist_new_ff;
   logic signed [15:0] smp_ff [LANES];
   logic        accept;
   logic        is_last;

   assign sel_book = BOOK_W'(req_book_select % NUM_BOOKS);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // memory write and registered read
   assign rd_addr = {book_ff, cnt_ff[3:0]};
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_LOAD) begin
         book_mem[{sel_book, req_coef_index}] <= req_coef_value;
      end
      rd_data_ff <= book_mem[rd_addr];
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      half_in  = half_ff;
      book_in  = book_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_DECODE) begin
               state_in = ST_FETCH;
               cnt_in   = '0;
               half_in  = 1'b0;
               book_in  = sel_book;
            end
         end
         ST_FETCH: begin
            // an extra fetch step drains the registered read
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = ST_LANE;
               cnt_in   = '0;
            end
         end
         ST_LANE: begin
            // steps 0..9 multiply, steps 1..10 accumulate
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd10) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            state_in = ST_EMIT;
            cnt_in   = '0;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd7) begin
                  if (half_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_LANE;
                     half_in  = 1'b1;
                     cnt_in   = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         half_ff  <= 1'b0;
         book_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         half_ff  <= half_in;
         book_ff  <= book_in;
      end
   end

   // frame payload and coefficient capture
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_DECODE) begin
         scale_ff <= req_scale;
         nib_ff   <= req_residual_nibbles;
      end
      if (state_ff == ST_FETCH && cnt_ff != 5'd0) begin
         coef_ff[4'(cnt_ff - 5'd1)] <= rd_data_ff;
      end
   end

   // history: reset, set transaction, restart, end of frame
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_old_ff <= '0;
         hist_new_ff <= '0;
      end else if (accept && req_type == REQ_HISTORY) begin
         hist_old_ff <= req_older_sample;
         hist_new_ff <= req_newer_sample;
      end else if (accept && req_type == REQ_DECODE && req_restart) begin
         hist_old_ff <= '0;
         hist_new_ff <= '0;
      end else if (state_ff == ST_EMIT && cnt_ff == 5'd7 && !rsp_stall && half_ff) begin
         hist_old_ff <= smp_ff[6];
         hist_new_ff <= smp_ff[7];
      end
   end

   // lane operands: step 0 older, 1 newer, 2 own residual x 2048,
   // 3+i earlier residual i weighted by c[8+j-1-i]
   lane_ctrl_type ctrl;
   logic [3:0]    step;
   logic signed [15:0] p_old, p_new;
   logic [31:0]   acc [LANES];

   assign step = cnt_ff[3:0];
   assign ctrl.mul_en = (state_ff == ST_LANE) && (cnt_ff < 5'd10);
   assign ctrl.sum_en = (state_ff == ST_LANE) && (cnt_ff != 5'd0);
   assign p_old = half_ff ? smp_ff[6] : hist_old_ff;
   assign p_new = half_ff ? smp_ff[7] : hist_new_ff;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic signed [15:0] lc;
      logic signed [31:0] lop;
      logic [3:0]         ri;
      logic [3:0]         nib_sel;
      always_comb begin
         lc  = '0;
         lop = '0;
         ri  = '0;
         if (step == 4'd0) begin
            lc  = coef_ff[j];
            lop = 32'(p_old);
         end else if (step == 4'd1) begin
            lc  = coef_ff[8 + j];
            lop = 32'(p_new);
         end else if (step == 4'd2) begin
            ri  = 4'(j);
            lc  = 16'sd2048;
            lop = 32'(residual_of(nib_sel, scale_ff));
         end else if (32'(step) - 3 < j) begin
            ri  = 4'(step - 4'd3);
            lc  = coef_ff[4'(8 + j - 1) - ri];
            lop = 32'(residual_of(nib_sel, scale_ff));
         end
      end
      assign nib_sel = nib_ff[6'(63 - 4 * (8 * half_ff + ri)) -: 4];
      vadpcm_lane u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .clear   (state_ff == ST_LANE && cnt_ff == 5'd0),
         .coef    (lc),
         .operand (lop),
         .acc     (acc[j])
      );
      // merge: wrap, shift, saturate
      always_ff @(posedge clock) begin
         if (state_ff == ST_MERGE) begin
            smp_ff[j] <= shift_sat(acc[j]);
         end
      end
   end

   assign is_last    = half_ff && cnt_ff == 5'd7;
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign rsp_sample = smp_ff[cnt_ff[2:0]];
   assign rsp_last   = rsp_valid && is_last;

   property p_busy_stall;
      @(posedge clock) disable iff (reset) rsp_valid |-> req_stall;
   endproperty
   assert property (p_busy_stall) else $error("input taken while results pending");

   property p_last_ends;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_last && !rsp_stall) |=> (state_ff == ST_IDLE);
   endproperty
   assert property (p_last_ends) else $error("frame did not end after last sample");

   property p_decode_starts;
      @(posedge clock) disable iff (reset)
         (accept && req_type == REQ_DECODE) |=> (state_ff == ST_FETCH);
   endproperty
   assert property (p_decode_starts) else $error("decode did not start fetch");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import vadpcm_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // request channel
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_LOAD;
   logic [3:0]         req_book_select = '0;
   logic [3:0]         req_coef_index = '0;
   logic signed [15:0] req_coef_value = '0;
   logic [3:0]         req_scale = '0;
   logic [63:0]        req_residual_nibbles = '0;
   logic               req_restart = 1'b0;
   logic signed [15:0] req_older_sample = '0;
   logic signed [15:0] req_newer_sample = '0;

   // response channel
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [15:0] rsp_sample;
   logic               rsp_last;

   order2_adpcm_frame_decoder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_book_select(req_book_select), .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value), .req_scale(req_scale),
      .req_residual_nibbles(req_residual_nibbles), .req_restart(req_restart),
      .req_older_sample(req_older_sample), .req_newer_sample(req_newer_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample), .rsp_last(rsp_last)
   );

   // predictor state: codebook shadow and history
   logic signed [15:0] coef_mem [256];
   bit                 coef_written [256];
   logic signed [15:0] hist_older, hist_newer;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } sample_exp_type;
   sample_exp_type pending_samples [$];

   // idling knobs, percent
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          recv_hold = 1'b0;

   int unsigned mismatches = 0;
   int unsigned frames_sent = 0;
   int unsigned samples_seen = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   localparam int unsigned QUIET_LIMIT = 20000;

   // arithmetic shift by 11 then clamp to 16 bits
   function automatic logic signed [15:0] clamp_sample(input logic [31:0] acc);
      logic signed [31:0] sh;
      begin
         sh = signed'(acc) >>> 11;
         if (sh > 32767) clamp_sample = 16'sh7fff;
         else if (sh < -32768) clamp_sample = 16'sh8000;
         else clamp_sample = sh[15:0];
      end
   endfunction

   // work out the sixteen samples of one frame and update history
   task automatic decode_frame(input logic [3:0] book, input logic [3:0] scl,
                               input logic [63:0] nibs, input logic rst);
      logic signed [31:0] resid [16];
      logic signed [31:0] cf [16];
      logic signed [15:0] out_s [16];
      logic signed [31:0] s4, p_old, p_new;
      logic [31:0]        acc;
      int                 base, h, j;
      begin
         base = (int'(book) % NUM_BOOKS) * 16;
         if (rst) begin
            hist_older = '0;
            hist_newer = '0;
         end
         for (int i = 0; i < 16; i++) begin
            cf[i] = coef_mem[(base + i) & 255];
            s4 = 32'(signed'(nibs[63 - 4*i -: 4]));
            resid[i] = (scl >= 4'd12) ? s4 * 4096 : s4 * (32'sd1 <<< scl);
         end
         for (int n = 0; n < 16; n++) begin
            h = n / 8;
            j = n % 8;
            p_old = (h == 0) ? 32'(hist_older) : 32'(out_s[6]);
            p_new = (h == 0) ? 32'(hist_newer) : 32'(out_s[7]);
            acc = cf[j] * p_old + cf[8 + j] * p_new;
            for (int i = 0; i < j; i++) acc += cf[8 + j - 1 - i] * resid[8*h + i];
            acc += resid[8*h + j] * 2048;
            out_s[n] = clamp_sample(acc);
            pending_samples.push_back('{sample: out_s[n], last: (n == 15)});
         end
         hist_older = out_s[14];
         hist_newer = out_s[15];
      end
   endtask

   // one transaction on the request channel, with random idle before it
   task automatic send_item(input req_code_type kind, input logic [3:0] book,
                            input logic [3:0] idx, input logic signed [15:0] cval,
                            input logic [3:0] scl, input logic [63:0] nibs,
                            input logic rst, input logic signed [15:0] older,
                            input logic signed [15:0] newer);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_type <= kind;
         req_book_select <= book;
         req_coef_index <= idx;
         req_coef_value <= cval;
         req_scale <= scl;
         req_residual_nibbles <= nibs;
         req_restart <= rst;
         req_older_sample <= older;
         req_newer_sample <= newer;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         // accepted at this edge: update the prediction
         items_sent++;
         case (kind)
            REQ_LOAD: begin
               coef_mem[((int'(book) % NUM_BOOKS) * 16 + idx) & 255] = cval;
               coef_written[((int'(book) % NUM_BOOKS) * 16 + idx) & 255] = 1'b1;
            end
            REQ_HISTORY: begin
               hist_older = older;
               hist_newer = newer;
            end
            REQ_DECODE: begin
               decode_frame(book, scl, nibs, rst);
               frames_sent++;
            end
            default: ;
         endcase
      end
   endtask

   task automatic load_coef(input logic [3:0] book, input logic [3:0] idx,
                            input logic signed [15:0] cval);
      send_item(REQ_LOAD, book, idx, cval, 4'($urandom), {$urandom, $urandom},
                1'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic set_history(input logic signed [15:0] older,
                              input logic signed [15:0] newer);
      send_item(REQ_HISTORY, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
                {$urandom, $urandom}, 1'($urandom), older, newer);
   endtask

   task automatic decode(input logic [3:0] book, input logic [3:0] scl,
                         input logic [63:0] nibs, input logic rst);
      send_item(REQ_DECODE, book, 4'($urandom), 16'($urandom), scl, nibs, rst,
                16'($urandom), 16'($urandom));
   endtask

   // a decode may only read a fully written book
   function automatic bit book_ready(input logic [3:0] book);
      begin
         book_ready = 1'b1;
         for (int i = 0; i < 16; i++)
            if (!coef_written[(int'(book) % NUM_BOOKS) * 16 + i]) book_ready = 1'b0;
      end
   endfunction

   task automatic fill_book(input logic [3:0] book, input int mode);
      logic signed [15:0] v;
      begin
         for (int i = 0; i < 16; i++) begin
            case (mode)
               0: v = 16'sh7fff;
               1: v = 16'sh8000;
               default: v = 16'($urandom);
            endcase
            load_coef(book, i[3:0], v);
         end
      end
   endtask

   function automatic logic [63:0] rand_nibbles();
      return {$urandom, $urandom};
   endfunction

   // response side: random stall plus an optional long hold
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      sample_exp_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_seen++;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample %0d last %0b", rsp_sample, rsp_last);
         end else begin
            exp_s = pending_samples.pop_front();
            if (rsp_sample !== exp_s.sample || rsp_last !== exp_s.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample mismatch: expected %0d/%0b got %0d/%0b",
                           exp_s.sample, exp_s.last, rsp_sample, rsp_last);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      begin
         req_valid <= 1'b0;
         while (pending_samples.size() != 0) @(posedge clock);
         repeat (80) @(posedge clock);
      end
   endtask

   // extremes of coefficients, residuals, scale and history
   task automatic test_directed();
      begin
         fill_book(4'd0, 0);
         fill_book(4'd1, 1);
         fill_book(4'd2, 2);
         decode(4'd0, 4'd0, 64'h7777_7777_7777_7777, 1'b1);
         decode(4'd1, 4'd15, 64'h8888_8888_8888_8888, 1'b0);
         set_history(16'sh7fff, 16'sh8000);
         decode(4'd2, 4'd12, 64'h0123_4567_89ab_cdef, 1'b0);
         decode(4'd2, 4'd11, 64'hffff_ffff_ffff_ffff, 1'b0);
         // unused request code is dropped
         send_item(REQ_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
                   rand_nibbles(), 1'($urandom), 16'($urandom), 16'($urandom));
         set_history(16'sh8000, 16'sh7fff);
         decode(4'd0, 4'd7, 64'h0000_0000_0000_0000, 1'b0);
         decode(4'd1, 4'd3, rand_nibbles(), 1'b1);
         wait_drained();
      end
   endtask

   // random frames over a few books, with loads, history sets and noise
   task automatic test_random(input int count);
      int          pick;
      logic [3:0]  book;
      begin
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            book = 4'($urandom);
            if (pick < 60) begin
               if (!book_ready(book)) book = 4'd2;
               decode(book, 4'($urandom), rand_nibbles(), $urandom_range(3) == 0);
            end else if (pick < 82) begin
               load_coef(book, 4'($urandom), 16'($urandom));
            end else if (pick < 94) begin
               set_history(16'($urandom), 16'($urandom));
            end else begin
               send_item(REQ_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom),
                         4'($urandom), rand_nibbles(), 1'($urandom),
                         16'($urandom), 16'($urandom));
            end
         end
         wait_drained();
      end
   endtask

   // receiver holds off for a long stretch while frames keep coming
   task automatic test_backpressure();
      begin
         fork
            begin
               recv_hold = 1'b1;
               repeat (400) @(posedge clock);
               recv_hold = 1'b0;
            end
            for (int n = 0; n < 6; n++)
               decode(4'd2, 4'($urandom), rand_nibbles(), 1'b0);
         join
         wait_drained();
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         coef_mem[i] = '0;
         coef_written[i] = 1'b0;
      end
      hist_older = '0;
      hist_newer = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      send_idle_pct = 37;
      recv_idle_pct = 51;
      test_random(14);
      send_idle_pct = 51;
      recv_idle_pct = 37;
      test_random(14);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(10);
      test_backpressure();

      $display("%0d transactions sent, %0d frames decoded, %0d samples checked",
               items_sent, frames_sent, samples_seen);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches, %0d samples outstanding", mismatches,
                  pending_samples.size());
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: order2_adpcm_frame_decoder.f
rtl/vadpcm_pkg.sv
rtl/vadpcm_lane.sv
rtl/order2_adpcm_frame_decoder.sv
sim/tb.sv
